// ===== rtl/tapid_pkg.sv =====
// Shared types and constants for the two-axis PID controller.
package tapid_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd4;

   // Datapath widths
   localparam int unsigned MUL_A_W = 48;   // signed multiplicand (integral range)
   localparam int unsigned MUL_B_W = 33;   // signed multiplier (gain or step time)
   localparam int unsigned PROD_W  = 64;   // floor(a*b / 2^16)
   localparam int unsigned NUM_W   = 49;   // |diff| << 16
   localparam int unsigned DER_W   = 47;   // saturated derivative

   // Iteration counts of the shared units
   localparam int unsigned MUL_PP    = 6;      // 3 x 2 chunks of 16 bits
   localparam int unsigned DIV_STEPS = NUM_W;  // one quotient bit per cycle

   // Request to the shared multiplier
   typedef struct packed {
      logic                       start;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mul_req_type;

   // Request to the serial divider
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [15:0]       den;
      logic              neg;
   } div_req_type;

endpackage

// ===== rtl/tapid_mul.sv =====
// Shared multiplier: floor(a*b / 2^16) from 16x16 partial products over several cycles.
module tapid_mul import tapid_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mul_req_type               req,
   output logic                      busy,
   output logic signed [PROD_W-1:0]  result
);

   typedef enum logic [3:0] {
      M_IDLE  = 4'b0001,
      M_RUN   = 4'b0010,
      M_DRAIN = 4'b0100,
      M_FIN   = 4'b1000
   } mul_state_type;

   mul_state_type             state_ff, state_in;
   logic [2:0]                step_ff, step_in;
   logic [MUL_A_W-1:0]        ua_ff, ua_in;
   logic [31:0]               ub_ff, ub_in;
   logic                      neg_ff, neg_in;
   logic [31:0]               pp_ff, pp_in;
   logic [1:0]                pp_sh_ff, pp_sh_in;
   logic                      pp_vld_ff, pp_vld_in;
   logic [79:0]               acc_ff, acc_in;
   logic signed [PROD_W-1:0]  result_ff, result_in;

   logic [15:0]               a_chunk;
   logic [15:0]               b_chunk;
   logic [79:0]               addend;
   logic [MUL_B_W-1:0]        b_abs;
   logic [63:0]               q;
   logic                      exact;

   // Operand chunk select
   always_comb begin
      case (step_ff[2:1])
         2'd0:    a_chunk = ua_ff[15:0];
         2'd1:    a_chunk = ua_ff[31:16];
         2'd2:    a_chunk = ua_ff[47:32];
         default: a_chunk = 16'd0;
      endcase
      b_chunk = step_ff[0] ? ub_ff[31:16] : ub_ff[15:0];
   end

   // Align registered partial product
   always_comb begin
      case (pp_sh_ff)
         2'd0:    addend = {48'd0, pp_ff};
         2'd1:    addend = {32'd0, pp_ff, 16'd0};
         2'd2:    addend = {16'd0, pp_ff, 32'd0};
         2'd3:    addend = {pp_ff, 48'd0};
         default: addend = 80'd0;
      endcase
   end

   // Sequencer and datapath
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      pp_in     = 32'(a_chunk) * 32'(b_chunk);
      pp_sh_in  = step_ff[2:1] + {1'b0, step_ff[0]};
      pp_vld_in = (state_ff == M_RUN);
      acc_in    = pp_vld_ff ? acc_ff + addend : acc_ff;
      b_abs     = req.b[MUL_B_W-1] ? (~req.b + 33'd1) : req.b;
      q         = acc_ff[79:16];
      exact     = ~(|acc_ff[15:0]);

      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               ua_in    = req.a[MUL_A_W-1] ? (~req.a + 48'd1) : req.a;
               ub_in    = b_abs[31:0];
               neg_in   = req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
               step_in  = 3'd0;
               acc_in   = 80'd0;
               state_in = M_RUN;
            end
         end
         M_RUN: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(MUL_PP - 1)) begin
               state_in = M_DRAIN;
            end
         end
         M_DRAIN: begin
            state_in = M_FIN;
         end
         M_FIN: begin
            // floor for negative: -(q + inexact) = ~q + exact
            result_in = neg_ff ? $signed(~q + {63'd0, exact}) : $signed(q);
            state_in  = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= M_IDLE;
         pp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pp_vld_ff <= pp_vld_in;
      end
      step_ff   <= step_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff    <= neg_in;
      pp_ff     <= pp_in;
      pp_sh_ff  <= pp_sh_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign busy   = (state_ff != M_IDLE);
   assign result = result_ff;

endmodule

// ===== rtl/tapid_div.sv =====
// Serial restoring divider for the derivative term, one quotient bit per cycle.
module tapid_div import tapid_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  div_req_type              req,
   output logic                     busy,
   output logic signed [DER_W-1:0]  deriv
);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } div_state_type;

   localparam logic [DER_W-1:0] DER_MAX = 47'h3FFF_FFFF_FFFF;
   localparam logic [DER_W-1:0] DER_MIN = 47'h4000_0000_0000;

   div_state_type            state_ff, state_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic [NUM_W-1:0]         work_ff, work_in;
   logic [15:0]              rem_ff, rem_in;
   logic [15:0]              den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic signed [DER_W-1:0]  deriv_ff, deriv_in;

   logic [16:0]              partial;
   logic [17:0]              trial;
   logic                     qbit;
   logic [NUM_W-1:0]         q_neg;
   logic                     sat_pos;
   logic                     sat_neg;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      deriv_in = deriv_ff;

      // One restoring step: shift in the next dividend bit, subtract if it fits
      partial = {rem_ff, work_ff[NUM_W-1]};
      trial   = {1'b0, partial} - {2'b00, den_ff};
      qbit    = ~trial[17];

      // Sign and saturate the magnitude quotient
      q_neg   = ~work_ff + 49'd1;
      sat_pos = |work_ff[48:46];
      sat_neg = (|work_ff[48:47]) | (work_ff[46] & (|work_ff[45:0]));

      case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               work_in  = req.num;
               den_in   = req.den;
               neg_in   = req.neg;
               rem_in   = 16'd0;
               cnt_in   = 6'd0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in  = qbit ? trial[15:0] : partial[15:0];
            work_in = {work_ff[NUM_W-2:0], qbit};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (neg_ff) begin
               deriv_in = sat_neg ? DER_MIN : q_neg[DER_W-1:0];
            end else begin
               deriv_in = sat_pos ? DER_MAX : work_ff[DER_W-1:0];
            end
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      deriv_ff <= deriv_in;
   end

   assign busy  = (state_ff != D_IDLE);
   assign deriv = deriv_ff;

endmodule

// ===== rtl/two_axis_pid_controller_top.sv =====
// Two-axis PID controller: per-axis PID with saturated integral and clamped output.
// One item in flight: req_ready is high only while the sequencer idles, so a new req beat
// is taken only once the last result is loaded, later while rsp_ready holds off the output.
// The serial divider for the derivative, then one pass of the shared multiplier for the
// D term, sets the time from an accepted req beat to rsp_valid.
// Reset (synchronous, active high) idles the sequencer, drops rsp_valid, loads register
// defaults and clears every axis integral and previous measurement.
module two_axis_pid_controller_top import tapid_pkg::*; #(
   parameter int unsigned AXES = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_axis,
   input  logic signed [31:0]    req_measurement,
   input  logic [15:0]           req_step_time,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_drive,
   output logic                  rsp_clamped,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;

   localparam logic signed [47:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] INTEG_MIN = 48'sh8000_0000_0000;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_START  = 8'b0000_0010,
      S_INTEG  = 8'b0000_0100,
      S_P_WAIT = 8'b0000_1000,
      S_I_WAIT = 8'b0001_0000,
      S_D_WAIT = 8'b0010_0000,
      S_M_WAIT = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } seq_state_type;

   seq_state_type              state_ff, state_in;

   // configuration registers
   logic signed [31:0]         setpoint_ff, setpoint_in;
   logic signed [31:0]         gain_p_ff, gain_p_in;
   logic signed [31:0]         gain_i_ff, gain_i_in;
   logic signed [31:0]         gain_d_ff, gain_d_in;
   logic [30:0]                limit_ff, limit_in;

   // per-axis state
   logic signed [47:0]         integ_ff [AXES];
   logic signed [47:0]         integ_in [AXES];
   logic signed [31:0]         prev_ff [AXES];
   logic signed [31:0]         prev_in [AXES];

   // item registers
   logic [AX_W-1:0]            ax_ff, ax_in;
   logic signed [31:0]         meas_ff, meas_in;
   logic [15:0]                dt_ff, dt_in;
   logic signed [32:0]         err_ff, err_in;
   logic signed [32:0]         diff_ff, diff_in;
   logic signed [PROD_W-1:0]   sum_ff, sum_in;

   // result registers
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]         rsp_drive_ff, rsp_drive_in;
   logic                       rsp_clamped_ff, rsp_clamped_in;

   // shared units
   mul_req_type                mul_req;
   logic                       mul_busy;
   logic signed [PROD_W-1:0]   mul_result;
   div_req_type                div_req;
   logic                       div_busy;
   logic signed [DER_W-1:0]    deriv;

   logic [32:0]                diff_abs;
   logic signed [48:0]         integ_sum;
   logic signed [47:0]         integ_sat;
   logic signed [PROD_W-1:0]   lim_pos;
   logic signed [PROD_W-1:0]   lim_neg;
   logic                       accept;
   logic                       rsp_load;

   tapid_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .busy   (mul_busy),
      .result (mul_result)
   );

   tapid_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .busy   (div_busy),
      .deriv  (deriv)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   // Configuration writes
   always_comb begin
      setpoint_in = setpoint_ff;
      gain_p_in   = gain_p_ff;
      gain_i_in   = gain_i_ff;
      gain_d_in   = gain_d_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SETPOINT:    setpoint_in = csr_wdata;
            CSR_GAIN_P:      gain_p_in   = csr_wdata;
            CSR_GAIN_I:      gain_i_in   = csr_wdata;
            CSR_GAIN_D:      gain_d_in   = csr_wdata;
            CSR_DRIVE_LIMIT: limit_in    = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Integral update with 48-bit saturation
   always_comb begin
      integ_sum = {integ_ff[ax_ff][47], integ_ff[ax_ff]} + mul_result[48:0];
      if (integ_sum[48] != integ_sum[47]) begin
         integ_sat = integ_sum[48] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[47:0];
      end
   end

   // Output clamp bounds
   assign lim_pos  = {33'd0, limit_ff};
   assign lim_neg  = -lim_pos;
   assign diff_abs = diff_ff[32] ? (~diff_ff + 33'd1) : diff_ff;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      ax_in       = ax_ff;
      meas_in     = meas_ff;
      dt_in       = dt_ff;
      err_in      = err_ff;
      diff_in     = diff_ff;
      sum_in      = sum_ff;
      integ_in    = integ_ff;
      prev_in     = prev_ff;
      mul_req     = '0;
      div_req     = '0;
      rsp_load    = 1'b0;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (AXES > 1) begin
                  ax_in = AX_W'(req_axis);
               end else begin
                  ax_in = '0;
               end
               meas_in  = req_measurement;
               dt_in    = req_step_time;
               err_in   = {setpoint_ff[31], setpoint_ff}
                        - {req_measurement[31], req_measurement};
               diff_in  = {req_measurement[31], req_measurement}
                        - {prev_ff[ax_in][31], prev_ff[ax_in]};
               state_in = S_START;
            end
         end
         S_START: begin
            // derivative divide and err*dt run side by side
            div_req.start = 1'b1;
            div_req.num   = {diff_abs, 16'd0};
            div_req.den   = (dt_ff == 16'd0) ? 16'd1 : dt_ff;
            div_req.neg   = diff_ff[32];
            mul_req.start = 1'b1;
            mul_req.a     = {{15{err_ff[32]}}, err_ff};
            mul_req.b     = {17'd0, dt_ff};
            prev_in[ax_ff] = meas_ff;
            state_in      = S_INTEG;
         end
         S_INTEG: begin
            if (!mul_busy) begin
               integ_in[ax_ff] = integ_sat;
               mul_req.start   = 1'b1;
               mul_req.a       = {{15{err_ff[32]}}, err_ff};
               mul_req.b       = {gain_p_ff[31], gain_p_ff};
               state_in        = S_P_WAIT;
            end
         end
         S_P_WAIT: begin
            if (!mul_busy) begin
               sum_in        = mul_result;
               mul_req.start = 1'b1;
               mul_req.a     = integ_ff[ax_ff];
               mul_req.b     = {gain_i_ff[31], gain_i_ff};
               state_in      = S_I_WAIT;
            end
         end
         S_I_WAIT: begin
            if (!mul_busy) begin
               sum_in   = sum_ff + mul_result;
               state_in = S_D_WAIT;
            end
         end
         S_D_WAIT: begin
            if (!div_busy) begin
               mul_req.start = 1'b1;
               mul_req.a     = {deriv[DER_W-1], deriv};
               mul_req.b     = {gain_d_ff[31], gain_d_ff};
               state_in      = S_M_WAIT;
            end
         end
         S_M_WAIT: begin
            if (!mul_busy) begin
               sum_in   = sum_ff + mul_result;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (sum_ff > lim_pos) begin
                  rsp_drive_in   = lim_pos[31:0];
                  rsp_clamped_in = 1'b1;
               end else if (sum_ff < lim_neg) begin
                  rsp_drive_in   = lim_neg[31:0];
                  rsp_clamped_in = 1'b1;
               end else begin
                  rsp_drive_in   = sum_ff[31:0];
                  rsp_clamped_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid tracking
   assign rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         setpoint_ff  <= 32'sd0;
         gain_p_ff    <= 32'sd6554;
         gain_i_ff    <= 32'sd328;
         gain_d_ff    <= 32'sd0;
         limit_ff     <= 31'd327680;
         for (int k = 0; k < AXES; k++) begin
            integ_ff[k] <= 48'sd0;
            prev_ff[k]  <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         setpoint_ff  <= setpoint_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         limit_ff     <= limit_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
      end
      ax_ff          <= ax_in;
      meas_ff        <= meas_in;
      dt_ff          <= dt_in;
      err_ff         <= err_in;
      diff_ff        <= diff_in;
      sum_ff         <= sum_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_START))
      else $error("accepted beat did not start the sequence");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_busy)
      else $error("multiplier started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_busy)
      else $error("divider started while busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result beat raised outside the output step");
`endif

endmodule
